>>> src/rpa_pkg.sv
`timescale 1ns / 1ps

package rpa_pkg;

	localparam logic [2:0] ACT_COMPL = 3'd0;
	localparam logic [2:0] ACT_BLEND = 3'd1;
	localparam logic [2:0] ACT_ADD   = 3'd2;
	localparam logic [2:0] ACT_SUB   = 3'd3;
	localparam logic [2:0] ACT_MUL   = 3'd4;
	localparam logic [2:0] ACT_DIV   = 3'd5;

	localparam logic [7:0] CH_MAX    = 8'd255;
	localparam logic [6:0] OP_MAX    = 7'd100;
	localparam logic [7:0] OP_MOD    = 8'd101;
	// floor(2^16 / 101); quotient estimate is exact or one low for products up to 10000
	localparam logic [9:0] MOD_RECIP = 10'd648;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] a_red;
		logic [7:0] a_green;
		logic [7:0] a_blue;
		logic [6:0] a_alpha;
		logic [7:0] b_red;
		logic [7:0] b_green;
		logic [7:0] b_blue;
		logic [6:0] b_alpha;
		logic       b_has_alpha;
	} req_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [6:0] out_alpha;
		logic       status;
	} rsp_t;

	// one lane of the restoring divider: num shifts out dividend bits, shifts in quotient bits
	typedef struct packed {
		logic [7:0] num;
		logic [7:0] rem;
		logic [7:0] den;
	} div_lane_t;

endpackage

>>> src/rgba_pixel_alu_core.sv
// Throughput: one request per cycle while rsp_ready does not stall the pipeline;
// the 8-bit quotients come from a restoring divider that retires two quotient
// bits per stage over four stages.
// Each stage holds its item while stalled and fills bubbles independently.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module rgba_pixel_alu_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rpa_pkg::rsp_t rsp
);
	import rpa_pkg::*;

	localparam int NLANE = 4;

	function automatic div_lane_t div_step(input div_lane_t l);
		logic [8:0] tmp;
		div_lane_t  o;
		tmp   = {l.rem, l.num[7]};
		o.den = l.den;
		if (tmp >= {1'b0, l.den}) begin
			o.rem = 8'(tmp - {1'b0, l.den});
			o.num = {l.num[6:0], 1'b1};
		end else begin
			o.rem = tmp[7:0];
			o.num = {l.num[6:0], 1'b0};
		end
		return o;
	endfunction

	// stage valids and per-stage ready
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || rsp_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// stage 1 front end: saturate opacity, direct results, products, divider setup
	logic [2:0][7:0] a_ch, b_ch, early_ch_d;
	logic [6:0]      ao, bo, early_al_d;
	logic [7:0]      al_sum;
	logic [13:0]     mprod_d;
	logic            err_d;
	div_lane_t       lanes_d [NLANE];

	always_comb begin
		logic [8:0]  sum9;
		logic [15:0] prod16;
		a_ch[0] = req.a_red;
		a_ch[1] = req.a_green;
		a_ch[2] = req.a_blue;
		b_ch[0] = req.b_red;
		b_ch[1] = req.b_green;
		b_ch[2] = req.b_blue;
		ao = (req.a_alpha > OP_MAX) ? OP_MAX : req.a_alpha;
		if (req.b_has_alpha)
			bo = (req.b_alpha > OP_MAX) ? OP_MAX : req.b_alpha;
		else
			bo = OP_MAX;
		al_sum  = {1'b0, ao} + {1'b0, bo};
		mprod_d = {7'd0, ao} * {7'd0, bo};
		early_al_d = '0;
		unique case (req.action)
			ACT_COMPL: early_al_d = OP_MAX - ao;
			ACT_BLEND: early_al_d = al_sum[7:1];
			ACT_ADD:   early_al_d = (al_sum >= OP_MOD) ? 7'(al_sum - OP_MOD) : al_sum[6:0];
			ACT_SUB:   early_al_d = (ao > bo) ? ao - bo : 7'd0;
			default:   early_al_d = '0;
		endcase
		for (int i = 0; i < 3; i++) begin
			sum9   = {1'b0, a_ch[i]} + {1'b0, b_ch[i]};
			prod16 = {8'd0, a_ch[i]} * {8'd0, b_ch[i]};
			unique case (req.action)
				ACT_COMPL: early_ch_d[i] = CH_MAX - a_ch[i];
				ACT_BLEND: early_ch_d[i] = sum9[8:1];
				ACT_ADD:   early_ch_d[i] = sum9[8] ? CH_MAX : sum9[7:0];
				ACT_SUB:   early_ch_d[i] = (a_ch[i] > b_ch[i]) ? a_ch[i] - b_ch[i] : 8'd0;
				ACT_MUL:   early_ch_d[i] = (prod16[15:8] != 8'd0) ? CH_MAX : prod16[7:0];
				default:   early_ch_d[i] = '0;
			endcase
			lanes_d[i].num = a_ch[i];
			lanes_d[i].rem = '0;
			lanes_d[i].den = b_ch[i];
		end
		lanes_d[3].num = {1'b0, ao};
		lanes_d[3].rem = '0;
		lanes_d[3].den = {1'b0, bo};
		err_d = (req.action == ACT_DIV) &&
			(req.b_red == 8'd0 || req.b_green == 8'd0 || req.b_blue == 8'd0 || bo == 7'd0);
	end

	// carried payload
	logic [2:0]      act_s1, act_s2, act_s3, act_s4, act_s5;
	logic            err_s1, err_s2, err_s3, err_s4, err_s5;
	logic [2:0][7:0] ech_s1, ech_s2, ech_s3, ech_s4, ech_s5;
	logic [6:0]      eal_s1, eal_s2, eal_s3, eal_s4, eal_s5;
	div_lane_t       lanes_s1 [NLANE];
	div_lane_t       lanes_s2 [NLANE];
	div_lane_t       lanes_s3 [NLANE];
	div_lane_t       lanes_s4 [NLANE];
	div_lane_t       lanes_s5 [NLANE];
	div_lane_t       ln2_d [NLANE];
	div_lane_t       ln3_d [NLANE];
	div_lane_t       ln4_d [NLANE];
	div_lane_t       ln5_d [NLANE];

	// opacity product mod 101: reciprocal estimate, back-multiply, one correction
	logic [13:0] mprod_s1, mprod_s2;
	logic [23:0] mq_full;
	logic [7:0]  mq_s2;
	logic [13:0] mqm, mdiff;
	logic [7:0]  mr_s3;
	logic [6:0]  mmod_d, mmod_s4, mmod_s5;

	assign mq_full = {10'd0, mprod_s1} * {14'd0, MOD_RECIP};
	assign mqm     = {6'd0, mq_s2} * {6'd0, OP_MOD};
	assign mdiff   = mprod_s2 - mqm;
	assign mmod_d  = (mr_s3 >= OP_MOD) ? 7'(mr_s3 - OP_MOD) : mr_s3[6:0];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			ln2_d[i] = div_step(div_step(lanes_s1[i]));
			ln3_d[i] = div_step(div_step(lanes_s2[i]));
			ln4_d[i] = div_step(div_step(lanes_s3[i]));
			ln5_d[i] = div_step(div_step(lanes_s4[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			act_s1   <= req.action;
			err_s1   <= err_d;
			ech_s1   <= early_ch_d;
			eal_s1   <= early_al_d;
			mprod_s1 <= mprod_d;
			lanes_s1 <= lanes_d;
		end
		if (rdy_s2) begin
			act_s2   <= act_s1;
			err_s2   <= err_s1;
			ech_s2   <= ech_s1;
			eal_s2   <= eal_s1;
			mprod_s2 <= mprod_s1;
			mq_s2    <= mq_full[23:16];
			lanes_s2 <= ln2_d;
		end
		if (rdy_s3) begin
			act_s3   <= act_s2;
			err_s3   <= err_s2;
			ech_s3   <= ech_s2;
			eal_s3   <= eal_s2;
			mr_s3    <= mdiff[7:0];
			lanes_s3 <= ln3_d;
		end
		if (rdy_s4) begin
			act_s4   <= act_s3;
			err_s4   <= err_s3;
			ech_s4   <= ech_s3;
			eal_s4   <= eal_s3;
			mmod_s4  <= mmod_d;
			lanes_s4 <= ln4_d;
		end
		if (rdy_s5) begin
			act_s5   <= act_s4;
			err_s5   <= err_s4;
			ech_s5   <= ech_s4;
			eal_s5   <= eal_s4;
			mmod_s5  <= mmod_s4;
			lanes_s5 <= ln5_d;
		end
	end

	// result select into the output register
	rsp_t rsp_d, rsp_s6;

	always_comb begin
		rsp_d = '0;
		unique case (act_s5)
			ACT_DIV: begin
				if (err_s5) begin
					rsp_d.status = 1'b1;
				end else begin
					rsp_d.out_red   = lanes_s5[0].num;
					rsp_d.out_green = lanes_s5[1].num;
					rsp_d.out_blue  = lanes_s5[2].num;
					rsp_d.out_alpha = lanes_s5[3].num[6:0];
				end
			end
			ACT_MUL: begin
				rsp_d.out_red   = ech_s5[0];
				rsp_d.out_green = ech_s5[1];
				rsp_d.out_blue  = ech_s5[2];
				rsp_d.out_alpha = mmod_s5;
			end
			default: begin
				rsp_d.out_red   = ech_s5[0];
				rsp_d.out_green = ech_s5[1];
				rsp_d.out_blue  = ech_s5[2];
				rsp_d.out_alpha = eal_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) rsp_s6 <= rsp_d;
	end

	assign rsp_valid = v_s6;
	assign rsp       = rsp_s6;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.out_red == 8'd0 && rsp.out_green == 8'd0 &&
			rsp.out_blue == 8'd0 && rsp.out_alpha == 7'd0)
		else $error("error result carries nonzero color");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.out_alpha <= OP_MAX)
		else $error("opacity out of range");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> mmod_s4 <= OP_MAX)
		else $error("mod 101 correction failed");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.action == ACT_DIV && req.b_red == 8'd0
		|=> v_s1 && err_s1)
		else $error("zero divisor not flagged");

endmodule

>>> tb/tb_rgba_pixel_alu_core.sv
`timescale 1ns / 1ps

module tb_rgba_pixel_alu_core;
	import rpa_pkg::*;

	// codes the block leaves unused; they must give an all-zero result with ok status
	localparam logic [2:0] ACT_RSVD6 = 3'd6;
	localparam logic [2:0] ACT_RSVD7 = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 2000;

	typedef struct {
		req_t stim;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// typed expectation travels with the request it belongs to
	bit   req_typed = 1'b0;
	rsp_t req_want = '0;

	rsp_t     expected_pixels[$];
	rsp_t     head_pixel;
	dir_row_t dir_rows[$];
	bit       idling = 1'b1;
	int       err_count = 0;
	int       quiet_cycles = 0;

	rgba_pixel_alu_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rsp_t pixel_result(req_t p);
		int unsigned ach[3];
		int unsigned bch[3];
		int unsigned res[3];
		int unsigned aop;
		int unsigned bop;
		int unsigned rop;
		logic        st;
		rsp_t        o;
		ach[0] = p.a_red;
		ach[1] = p.a_green;
		ach[2] = p.a_blue;
		bch[0] = p.b_red;
		bch[1] = p.b_green;
		bch[2] = p.b_blue;
		aop = (p.a_alpha > OP_MAX) ? OP_MAX : p.a_alpha;
		if (!p.b_has_alpha)
			bop = OP_MAX;
		else
			bop = (p.b_alpha > OP_MAX) ? OP_MAX : p.b_alpha;
		rop = 0;
		st = 1'b0;
		for (int i = 0; i < 3; i++)
			res[i] = 0;
		case (p.action)
			ACT_COMPL: begin
				for (int i = 0; i < 3; i++)
					res[i] = CH_MAX - ach[i];
				rop = OP_MAX - aop;
			end
			ACT_BLEND: begin
				for (int i = 0; i < 3; i++)
					res[i] = (ach[i] + bch[i]) / 2;
				rop = (aop + bop) / 2;
			end
			ACT_ADD: begin
				for (int i = 0; i < 3; i++)
					res[i] = (ach[i] + bch[i] > CH_MAX) ? CH_MAX : ach[i] + bch[i];
				rop = (aop + bop) % OP_MOD;
			end
			ACT_SUB: begin
				for (int i = 0; i < 3; i++)
					res[i] = (ach[i] > bch[i]) ? ach[i] - bch[i] : 0;
				rop = (aop > bop) ? aop - bop : 0;
			end
			ACT_MUL: begin
				for (int i = 0; i < 3; i++)
					res[i] = (ach[i] * bch[i] > CH_MAX) ? CH_MAX : ach[i] * bch[i];
				rop = (aop * bop) % OP_MOD;
			end
			ACT_DIV: begin
				if (bch[0] == 0 || bch[1] == 0 || bch[2] == 0 || bop == 0) begin
					st = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++)
						res[i] = ach[i] / bch[i];
					rop = (aop / bop) % OP_MOD;
				end
			end
			default: begin
			end
		endcase
		o.out_red = 8'(res[0]);
		o.out_green = 8'(res[1]);
		o.out_blue = 8'(res[2]);
		o.out_alpha = 7'(rop);
		o.status = st;
		return o;
	endfunction

	function automatic req_t pix_req(logic [2:0] act, int ar, int ag, int ab, int aa,
			int br, int bg, int bb, int ba, int bh);
		return {act, 8'(ar), 8'(ag), 8'(ab), 7'(aa), 8'(br), 8'(bg), 8'(bb), 7'(ba), 1'(bh)};
	endfunction

	function automatic rsp_t pix_rsp(int r, int g, int b, int a, int s);
		return {8'(r), 8'(g), 8'(b), 7'(a), 1'(s)};
	endfunction

	task automatic add_row(req_t s, bit typed, rsp_t w);
		dir_row_t row;
		row.stim = s;
		row.typed = typed;
		row.want = w;
		dir_rows.push_back(row);
	endtask

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 3));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly legal opacity, some above 100 to hit saturation
	function automatic logic [6:0] rand_alpha();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'($urandom_range(101, 127));
			default: return 7'($urandom_range(0, 100));
		endcase
	endfunction

	function automatic req_t rand_pixel();
		req_t p;
		int   pick;
		pick = $urandom_range(0, 19);
		p.action = (pick < 18) ? 3'(pick % 6) : ((pick == 18) ? ACT_RSVD6 : ACT_RSVD7);
		p.a_red = rand_channel();
		p.a_green = rand_channel();
		p.a_blue = rand_channel();
		p.a_alpha = rand_alpha();
		p.b_red = rand_channel();
		p.b_green = rand_channel();
		p.b_blue = rand_channel();
		p.b_alpha = rand_alpha();
		p.b_has_alpha = 1'($urandom_range(0, 1));
		return p;
	endfunction

	task automatic send_pixel(req_t p, bit typed, rsp_t want);
		@(negedge clk);
		if (idling && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req <= p;
		req_typed <= typed;
		req_want <= want;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_pixels.push_back(req_typed ? req_want : pixel_result(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected result: red %0d green %0d blue %0d alpha %0d status %0d",
						rsp.out_red, rsp.out_green, rsp.out_blue, rsp.out_alpha, rsp.status);
					err_count++;
				end else begin
					head_pixel = expected_pixels.pop_front();
					check_field("out_red", head_pixel.out_red, rsp.out_red);
					check_field("out_green", head_pixel.out_green, rsp.out_green);
					check_field("out_blue", head_pixel.out_blue, rsp.out_blue);
					check_field("out_alpha", head_pixel.out_alpha, rsp.out_alpha);
					check_field("status", head_pixel.status, rsp.status);
				end
			end
		end
	end

	// watchdog: too long with no request or result moving
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		rsp_t none;
		none = '0;

		add_row(pix_req(ACT_COMPL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, pix_rsp(255, 255, 255, 100, 0));
		add_row(pix_req(ACT_COMPL, 255, 255, 255, 100, 255, 255, 255, 127, 1), 1,
			pix_rsp(0, 0, 0, 0, 0));
		// opacity above 100 saturates before the complement
		add_row(pix_req(ACT_COMPL, 12, 34, 56, 127, 1, 2, 3, 4, 1), 1, pix_rsp(243, 221, 199, 0, 0));
		add_row(pix_req(ACT_BLEND, 255, 255, 255, 100, 255, 255, 255, 100, 1), 1,
			pix_rsp(255, 255, 255, 100, 0));
		add_row(pix_req(ACT_BLEND, 0, 255, 1, 0, 255, 0, 0, 0, 0), 1, pix_rsp(127, 127, 0, 50, 0));
		add_row(pix_req(ACT_BLEND, 3, 7, 200, 127, 9, 8, 100, 127, 1), 0, none);
		add_row(pix_req(ACT_ADD, 255, 200, 0, 100, 1, 55, 0, 100, 1), 1, pix_rsp(255, 255, 0, 99, 0));
		add_row(pix_req(ACT_ADD, 10, 20, 30, 1, 5, 6, 7, 127, 0), 0, none);
		add_row(pix_req(ACT_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, pix_rsp(0, 0, 0, 0, 0));
		add_row(pix_req(ACT_SUB, 0, 10, 255, 0, 255, 10, 0, 100, 1), 1, pix_rsp(0, 0, 255, 0, 0));
		add_row(pix_req(ACT_SUB, 200, 100, 50, 100, 100, 50, 25, 127, 1), 0, none);
		add_row(pix_req(ACT_SUB, 255, 255, 255, 100, 0, 0, 0, 0, 1), 1,
			pix_rsp(255, 255, 255, 100, 0));
		add_row(pix_req(ACT_MUL, 255, 16, 1, 100, 255, 16, 0, 100, 1), 1, pix_rsp(255, 255, 0, 1, 0));
		add_row(pix_req(ACT_MUL, 3, 5, 15, 77, 4, 17, 17, 55, 1), 0, none);
		add_row(pix_req(ACT_DIV, 255, 255, 0, 100, 1, 255, 7, 1, 1), 1, pix_rsp(255, 1, 0, 100, 0));
		// each divisor term alone being zero raises the error
		add_row(pix_req(ACT_DIV, 9, 9, 9, 50, 0, 3, 3, 10, 1), 1, pix_rsp(0, 0, 0, 0, 1));
		add_row(pix_req(ACT_DIV, 9, 9, 9, 50, 3, 0, 3, 10, 1), 1, pix_rsp(0, 0, 0, 0, 1));
		add_row(pix_req(ACT_DIV, 9, 9, 9, 50, 3, 3, 0, 10, 1), 1, pix_rsp(0, 0, 0, 0, 1));
		add_row(pix_req(ACT_DIV, 9, 9, 9, 50, 3, 3, 3, 0, 1), 1, pix_rsp(0, 0, 0, 0, 1));
		// absent second opacity counts as 100, so a zero b_alpha is ignored
		add_row(pix_req(ACT_DIV, 200, 99, 7, 100, 3, 4, 2, 0, 0), 0, none);
		add_row(pix_req(ACT_DIV, 128, 64, 255, 127, 2, 2, 255, 3, 1), 0, none);
		add_row(pix_req(ACT_RSVD6, 17, 18, 19, 20, 0, 0, 0, 0, 1), 1, pix_rsp(0, 0, 0, 0, 0));
		add_row(pix_req(ACT_RSVD7, 255, 255, 255, 127, 255, 255, 255, 127, 1), 1,
			pix_rsp(0, 0, 0, 0, 0));

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_pixel(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
		wait_drained();

		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			idling = (n < RANDOM_PIXELS - 300) && ((n / 200) % 3 != 2);
			if (n == RANDOM_PIXELS / 2)
				wait_drained();
			send_pixel(rand_pixel(), 1'b0, none);
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
